[sv/aes128_block_cipher_ecb_cbc_macros.svh]
// assertion macros for the aes block checker
`ifndef AES128_BLOCK_CIPHER_ECB_CBC_MACROS_SVH
`define AES128_BLOCK_CIPHER_ECB_CBC_MACROS_SVH

// antecedent holds, consequent holds in the next cycle
`define AES_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

// antecedent holds, consequent holds later, after the delay in the property
`define AES_CHK_LATER(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> ##9 (cons)) else $error(msg);

`endif

[sv/aes_pkg.sv]
// shared types, tables and round functions for the aes block
package aes_pkg;

	localparam int NROUND = 10;

	localparam logic [2:0] REG_KEY_HIGH    = 3'd0;
	localparam logic [2:0] REG_KEY_LOW     = 3'd1;
	localparam logic [2:0] REG_CHAIN_MODE  = 3'd2;
	localparam logic [2:0] REG_DIRECTION   = 3'd3;
	localparam logic [2:0] REG_ROUND_COUNT = 3'd4;

	typedef struct packed {
		logic        chain_start;
		logic [63:0] block_high;
		logic [63:0] block_low;
	} in_t;

	typedef struct packed {
		logic [63:0] out_high;
		logic [63:0] out_low;
	} out_t;

	typedef struct packed {
		logic [127:0] st;
		logic [127:0] pv;
	} cell_t;

	typedef struct packed {
		logic       active;
		logic       last;
		logic       dec;
	} rctl_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] ISBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	localparam logic [3:0] MIX_FW [4] = '{4'h2, 4'h3, 4'h1, 4'h1};
	localparam logic [3:0] MIX_IV [4] = '{4'he, 4'hb, 4'hd, 4'h9};

	function automatic logic [7:0] xt(logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(logic [7:0] a, logic [3:0] c);
		logic [7:0] x2, x4, x8;
		x2 = xt(a);
		x4 = xt(x2);
		x8 = xt(x4);
		return (c[0] ? a : 8'h00) ^ (c[1] ? x2 : 8'h00) ^ (c[2] ? x4 : 8'h00)
			^ (c[3] ? x8 : 8'h00);
	endfunction

	function automatic logic [7:0] rcon(logic [3:0] i);
		logic [7:0] r;
		unique case (i)
			4'd1: r = 8'h01;
			4'd2: r = 8'h02;
			4'd3: r = 8'h04;
			4'd4: r = 8'h08;
			4'd5: r = 8'h10;
			4'd6: r = 8'h20;
			4'd7: r = 8'h40;
			4'd8: r = 8'h80;
			4'd9: r = 8'h1b;
			4'd10: r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [127:0] sub_bytes(logic [127:0] s, logic inv);
		logic [127:0] o;
		for (int i = 0; i < 16; i++) begin
			o[127-8*i -: 8] = inv ? ISBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
		end
		return o;
	endfunction

	function automatic logic [127:0] shift_rows(logic [127:0] s, logic inv);
		logic [127:0] o;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (inv) begin
					o[127-8*(4*c+r) -: 8] = s[127-8*(4*((c+4-r)%4)+r) -: 8];
				end else begin
					o[127-8*(4*c+r) -: 8] = s[127-8*(4*((c+r)%4)+r) -: 8];
				end
			end
		end
		return o;
	endfunction

	function automatic logic [127:0] mix_columns(logic [127:0] s, logic inv);
		logic [127:0] o;
		logic [7:0]   v;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				v = 8'h00;
				for (int k = 0; k < 4; k++) begin
					v = v ^ gmul(s[127-8*(4*c+k) -: 8],
						inv ? MIX_IV[(k+4-r)%4] : MIX_FW[(k+4-r)%4]);
				end
				o[127-8*(4*c+r) -: 8] = v;
			end
		end
		return o;
	endfunction

	function automatic logic [127:0] key_next(logic [127:0] k, logic [7:0] rc);
		logic [31:0] t, w0, w1, w2, w3;
		t  = {SBOX[k[23:16]], SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
		t  = t ^ {rc, 24'h000000};
		w0 = k[127:96] ^ t;
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

[sv/aes_kcell.sv]
// key expansion cell: derives one round key from its neighbor's
module aes_kcell import aes_pkg::*; (
	input  logic         clk,
	input  logic [3:0]   round_idx,
	input  logic [127:0] prev_key,
	output logic [127:0] round_key
);

	logic [127:0] key_q;

	always_ff @(posedge clk) begin
		key_q <= key_next(prev_key, rcon(round_idx));
	end

	assign round_key = key_q;

endmodule

[sv/aes_rcell.sv]
// round cell: one encrypt or decrypt round on the item in this stage, or a pass-through when inactive
module aes_rcell import aes_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         adv,
	input  logic         vld_in,
	input  cell_t        d_in,
	input  logic [127:0] key,
	input  rctl_t        ctl,
	output logic         vld_out,
	output cell_t        d_out
);

	logic [127:0] fw_a, iv_a, rnd;
	logic         vld_q;
	cell_t        d_q;

	always_comb begin
		fw_a = shift_rows(sub_bytes(d_in.st, 1'b0), 1'b0);
		if (!ctl.last) begin
			fw_a = mix_columns(fw_a, 1'b0);
		end
		fw_a = fw_a ^ key;
		iv_a = sub_bytes(shift_rows(d_in.st, 1'b1), 1'b1) ^ key;
		if (!ctl.last) begin
			iv_a = mix_columns(iv_a, 1'b1);
		end
		if (!ctl.active) begin
			rnd = d_in.st;
		end else if (ctl.dec) begin
			rnd = iv_a;
		end else begin
			rnd = fw_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_q.st <= rnd;
			d_q.pv <= d_in.pv;
		end
	end

	assign vld_out = vld_q;
	assign d_out   = d_q;

endmodule

[sv/aes128_block_cipher_ecb_cbc.sv]
// aes-128 ecb/cbc top level: config registers, key chain, round chain, output register
// One item is a 128-bit block; the edge that accepts it loads the input stage, then the item
// moves through ten round cells and one output register, all held while the output stalls. ECB
// and CBC decryption take an item every cycle unless the output stalls or the round keys settle.
// CBC encryption feeds each ciphertext back into the next block, so the next item is taken only
// once the previous result has left the output register. The round keys come from a chain of ten
// key cells; after reset and each key register write, in_ready stays low while the chain refills.
module aes128_block_cipher_ecb_cbc import aes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_item
);

	logic [63:0]  key_high_q, key_low_q;
	logic         chain_mode_q, direction_q;
	logic [3:0]   round_count_q, settle_q, nr;
	logic [127:0] cv_q, cv_sel, blk, res;
	logic [127:0] rk [NROUND+1];
	logic [127:0] ck [NROUND+1];
	rctl_t        ctl [NROUND+1];
	logic         vld [NROUND+1];
	cell_t        cd  [NROUND+1];
	logic         adv, accept, empty, cbc_enc, key_wr, any_vld;
	logic         out_valid_q;
	out_t         out_q;
	logic         vld0_q;
	cell_t        d0_q;

	assign cfg_ready = 1'b1;
	assign key_wr = cfg_valid && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q    <= '0;
			key_low_q     <= '0;
			chain_mode_q  <= 1'b0;
			direction_q   <= 1'b0;
			round_count_q <= 4'd10;
			settle_q      <= 4'd11;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_KEY_HIGH:    key_high_q    <= cfg_data;
					REG_KEY_LOW:     key_low_q     <= cfg_data;
					REG_CHAIN_MODE:  chain_mode_q  <= cfg_data[0];
					REG_DIRECTION:   direction_q   <= cfg_data[0];
					REG_ROUND_COUNT: round_count_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (key_wr) begin
				settle_q <= 4'd11;
			end else if (settle_q != 4'd0) begin
				settle_q <= settle_q - 4'd1;
			end
		end
	end

	always_comb begin
		if (round_count_q == 4'd0) begin
			nr = 4'd1;
		end else if (round_count_q > 4'd10) begin
			nr = 4'd10;
		end else begin
			nr = round_count_q;
		end
	end

	assign rk[0] = {key_high_q, key_low_q};

	for (genvar i = 1; i <= NROUND; i++) begin : g_key
		aes_kcell u_kcell (
			.clk       (clk),
			.round_idx (4'(i)),
			.prev_key  (rk[i-1]),
			.round_key (rk[i])
		);
	end

	always_comb begin
		for (int j = 0; j <= NROUND; j++) begin
			if (direction_q) begin
				ck[j] = (nr >= 4'(j)) ? rk[nr - 4'(j)] : rk[0];
			end else begin
				ck[j] = rk[j];
			end
			ctl[j].active = (4'(j) <= nr);
			ctl[j].last   = (4'(j) == nr);
			ctl[j].dec    = direction_q;
		end
	end

	always_comb begin
		any_vld = vld0_q;
		for (int j = 1; j <= NROUND; j++) begin
			any_vld = any_vld | vld[j];
		end
	end

	assign cbc_enc  = chain_mode_q && !direction_q;
	assign empty    = !any_vld && !out_valid_q;
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv && (settle_q == 4'd0) && (!cbc_enc || empty);
	assign accept   = in_valid && in_ready;
	assign cv_sel   = in_item.chain_start ? 128'd0 : cv_q;
	assign blk      = {in_item.block_high, in_item.block_low} ^ (cbc_enc ? cv_sel : 128'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld0_q      <= 1'b0;
			out_valid_q <= 1'b0;
			cv_q        <= '0;
		end else begin
			if (adv) begin
				vld0_q      <= accept;
				out_valid_q <= vld[NROUND];
			end
			if (accept && chain_mode_q && direction_q) begin
				cv_q <= {in_item.block_high, in_item.block_low};
			end else if (accept && in_item.chain_start) begin
				cv_q <= '0;
			end else if (adv && vld[NROUND] && cbc_enc) begin
				cv_q <= res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d0_q.st <= blk ^ ck[0];
			d0_q.pv <= cv_sel;
			out_q   <= res;
		end
	end

	assign vld[0] = vld0_q;
	assign cd[0]  = d0_q;

	for (genvar j = 1; j <= NROUND; j++) begin : g_round
		aes_rcell u_rcell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.vld_in  (vld[j-1]),
			.d_in    (cd[j-1]),
			.key     (ck[j]),
			.ctl     (ctl[j]),
			.vld_out (vld[j]),
			.d_out   (cd[j])
		);
	end

	assign res = (chain_mode_q && direction_q) ? (cd[NROUND].st ^ cd[NROUND].pv)
		: cd[NROUND].st;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[sv/aes_chk.sv]
// port checker for the aes block, bound to the top level
`include "aes128_block_cipher_ecb_cbc_macros.svh"

module aes_chk import aes_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [2:0]  cfg_index,
	input logic [63:0] cfg_data,
	input logic        in_valid,
	input logic        in_ready,
	input in_t         in_item,
	input logic        out_valid,
	input logic        out_ready,
	input out_t        out_item
);

	logic key_wr;
	assign key_wr = cfg_valid && cfg_ready
		&& (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);

	`AES_CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "result item dropped or changed while stalled")
	`AES_CHK_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_item), "input item dropped or changed while stalled")
	`AES_CHK_NEXT(a_cfg_hold, cfg_valid && !cfg_ready, cfg_valid && $stable({cfg_index, cfg_data}), "config write dropped or changed while stalled")
	`AES_CHK_NEXT(a_key_block, key_wr, !in_ready, "item taken right after key write")
	`AES_CHK_LATER(a_key_settle, key_wr, !in_ready, "item taken before round keys settled")

endmodule

bind aes128_block_cipher_ecb_cbc aes_chk u_aes_chk (.*);

[verif/aes128_block_cipher_ecb_cbc_test.sv]
// self-checking testbench for the aes-128 ecb/cbc block with a built-in cipher predictor
module aes128_block_cipher_ecb_cbc_test;
	import aes_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 5000;
	localparam int ITEM_TARGET = 1050;
	localparam int DRAIN_CYCLES = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_t         in_item = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_t        out_item;

	aes128_block_cipher_ecb_cbc dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [7:0]   fwd_sub [256];
	logic [7:0]   inv_sub [256];
	logic [63:0]  key_hi = '0, key_lo = '0;
	logic         cbc_on = 1'b0, decrypt_on = 1'b0;
	logic [3:0]   rounds = 4'd10;
	logic [127:0] chain = '0;

	in_t  pending_blocks [$];
	out_t expected_blocks [$];
	int   send_idle = 0, recv_idle = 0;
	int   mismatches = 0;
	int   stall_cycles = 0;

	function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p = p ^ a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	function automatic void build_sboxes();
		logic [7:0] inv, b;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h00;
			for (int y = 1; y < 256; y++) begin
				if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
			end
			b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
				^ {inv[3:0], inv[7:4]} ^ 8'h63;
			fwd_sub[x] = b;
			inv_sub[b] = x[7:0];
		end
	endfunction

	function automatic logic [127:0] byte_sub(logic [127:0] v, logic inv);
		logic [127:0] o;
		for (int i = 0; i < 16; i++)
			o[127-8*i -: 8] = inv ? inv_sub[v[127-8*i -: 8]] : fwd_sub[v[127-8*i -: 8]];
		return o;
	endfunction

	function automatic logic [127:0] row_shift(logic [127:0] v, logic inv);
		logic [127:0] o;
		int src;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				src = inv ? (c + 4 - r) % 4 : (c + r) % 4;
				o[127-8*(4*c+r) -: 8] = v[127-8*(4*src+r) -: 8];
			end
		end
		return o;
	endfunction

	function automatic logic [127:0] column_mix(logic [127:0] v, logic inv);
		logic [7:0]   fw [4], iv [4], acc;
		logic [127:0] o;
		fw = '{8'h02, 8'h03, 8'h01, 8'h01};
		iv = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				acc = 8'h00;
				for (int k = 0; k < 4; k++)
					acc = acc ^ gf_mul(v[127-8*(4*c+k) -: 8],
						inv ? iv[(k+4-r)%4] : fw[(k+4-r)%4]);
				o[127-8*(4*c+r) -: 8] = acc;
			end
		end
		return o;
	endfunction

	// encrypts or decrypts one block and, in CBC mode, advances the chaining value
	function automatic out_t cipher_block(in_t item);
		logic [31:0]  w [44];
		logic [31:0]  t;
		logic [7:0]   rc;
		logic [127:0] rkey [11];
		logic [127:0] blk, s;
		int           n;
		n = (rounds < 1) ? 1 : (rounds > 10) ? 10 : rounds;
		if (item.chain_start) chain = '0;
		{w[0], w[1], w[2], w[3]} = {key_hi, key_lo};
		rc = 8'h01;
		for (int i = 4; i < 44; i++) begin
			t = w[i-1];
			if (i % 4 == 0) begin
				t = {t[23:0], t[31:24]};
				t = {fwd_sub[t[31:24]], fwd_sub[t[23:16]], fwd_sub[t[15:8]], fwd_sub[t[7:0]]};
				t[31:24] = t[31:24] ^ rc;
				rc = gf_mul(rc, 8'h02);
			end
			w[i] = w[i-4] ^ t;
		end
		for (int r = 0; r < 11; r++) rkey[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
		blk = {item.block_high, item.block_low};
		if (!decrypt_on) begin
			s = (cbc_on ? blk ^ chain : blk) ^ rkey[0];
			for (int i = 1; i <= n; i++) begin
				s = row_shift(byte_sub(s, 1'b0), 1'b0);
				if (i != n) s = column_mix(s, 1'b0);
				s = s ^ rkey[i];
			end
			if (cbc_on) chain = s;
		end else begin
			s = blk ^ rkey[n];
			for (int i = n - 1; i >= 0; i--) begin
				s = byte_sub(row_shift(s, 1'b1), 1'b1) ^ rkey[i];
				if (i != 0) s = column_mix(s, 1'b1);
			end
			if (cbc_on) begin
				s = s ^ chain;
				chain = blk;
			end
		end
		return '{out_high: s[127:64], out_low: s[63:0]};
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [63:0] data);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_KEY_HIGH:    key_hi = data;
			REG_KEY_LOW:     key_lo = data;
			REG_CHAIN_MODE:  cbc_on = data[0];
			REG_DIRECTION:   decrypt_on = data[0];
			REG_ROUND_COUNT: rounds = data[3:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		wait (pending_blocks.size() == 0 && !in_valid && expected_blocks.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [63:0] pick_word();
		int k;
		k = $urandom_range(9);
		if (k == 0) return '0;
		if (k == 1) return '1;
		return {$urandom, $urandom};
	endfunction

	task automatic queue_block(logic start, logic [63:0] hi, logic [63:0] lo);
		in_t item;
		item = '{chain_start: start, block_high: hi, block_low: lo};
		pending_blocks.push_back(item);
		expected_blocks.push_back(cipher_block(item));
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (pending_blocks.size() > 0 && $urandom_range(99) >= send_idle) begin
				in_item <= pending_blocks.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_cycles <= 0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("aes128_block_cipher_ecb_cbc_test: errors");
				$finish;
			end
			if (out_valid && out_ready) begin
				if (expected_blocks.size() == 0) begin
					if (mismatches < 10) $display("unexpected item %h", out_item);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_blocks.pop_front();
					if (want.out_high !== out_item.out_high || want.out_low !== out_item.out_low) begin
						if (mismatches < 10)
							$display("mismatch: expected %h_%h got %h_%h", want.out_high,
								want.out_low, out_item.out_high, out_item.out_low);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

	initial begin
		int total, count;
		logic [3:0] dir_rounds [6];
		build_sboxes();
		dir_rounds = '{4'd10, 4'd10, 4'd1, 4'd0, 4'd15, 4'd10};
		total = 0;
		send_idle = 15;
		recv_idle = 85;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, then each mode and direction with key and round extremes
		queue_block(1'b1, '0, '0);
		queue_block(1'b0, '1, '1);
		wait_idle();
		for (int p = 0; p < 6; p++) begin
			write_reg(REG_KEY_HIGH, (p == 5) ? '1 : (p == 0) ? '0 : 64'h2b7e151628aed2a6);
			write_reg(REG_KEY_LOW, (p == 5) ? '1 : (p == 0) ? '0 : 64'habf7158809cf4f3c);
			write_reg(REG_CHAIN_MODE, {63'd0, p[1]});
			write_reg(REG_DIRECTION, {63'd0, p[0]});
			write_reg(REG_ROUND_COUNT, {60'd0, dir_rounds[p]});
			queue_block(1'b1, '0, '0);
			queue_block(1'b0, '1, '1);
			queue_block(1'b0, 64'h3243f6a8885a308d, 64'h313198a2e0370734);
			wait_idle();
		end
		write_reg(3'($urandom_range(5, 7)), {$urandom, $urandom});
		total = 20;

		while (total < ITEM_TARGET) begin
			if (total >= 2 * ITEM_TARGET / 3) begin
				send_idle = 0;
				recv_idle = 0;
			end else if (total >= ITEM_TARGET / 3) begin
				send_idle = 85;
				recv_idle = 15;
			end
			write_reg(REG_KEY_HIGH, pick_word());
			write_reg(REG_KEY_LOW, pick_word());
			write_reg(REG_CHAIN_MODE, {63'd0, 1'($urandom)});
			write_reg(REG_DIRECTION, {63'd0, 1'($urandom)});
			write_reg(REG_ROUND_COUNT,
				($urandom_range(1) == 0) ? 64'd10 : 64'($urandom_range(15)));
			if ($urandom_range(7) == 0)
				write_reg(3'($urandom_range(5, 7)), {$urandom, $urandom});
			count = $urandom_range(20, 60);
			for (int i = 0; i < count; i++)
				queue_block((i == 0) ? ($urandom_range(3) != 0) : ($urandom_range(7) == 0),
					pick_word(), pick_word());
			total += count;
			wait_idle();
		end

		if (mismatches == 0)
			$display("aes128_block_cipher_ecb_cbc_test: clean");
		else
			$display("aes128_block_cipher_ecb_cbc_test: errors");
		$finish;
	end

endmodule
